[rtl/core/sgr_pkg.sv]
// Shared types and constants of the Sobel gradient unit.
package sgr_pkg;

    // Fixed field widths of the configuration registers and the result word.
    localparam int CFG_WIDTH_BITS  = 12;
    localparam int CFG_HEIGHT_BITS = 16;
    localparam int GRAD_W          = 11;
    localparam int COL_W           = 11;
    localparam int ROW_W           = 16;
    localparam int NUM_SLOTS       = 4;
    localparam int OUT_FIELDS_W    = 2 * GRAD_W + COL_W + ROW_W;
    localparam int OUT_TDATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    typedef logic [$clog2(NUM_SLOTS)-1:0] t_slot;

    // Up to four results caused by one pixel. Slot 0 is (x-1,y-1), slot 1 is
    // (x,y-1), slot 2 is (x-1,y) and slot 3 is (x,y).
    typedef struct packed {
        logic [NUM_SLOTS-1:0]              pend;
        logic [NUM_SLOTS-1:0][GRAD_W-1:0]  gx;
        logic [NUM_SLOTS-1:0][GRAD_W-1:0]  gy;
        logic [COL_W-1:0]                  col_a;
        logic [COL_W-1:0]                  col_b;
        logic [ROW_W-1:0]                  row_a;
        logic [ROW_W-1:0]                  row_b;
    } t_result_set;

endpackage

[rtl/core/sobel_gradient_3x3_unit.sv]
// Streaming 3x3 Sobel gradient unit with replicated frame border.
//
// Pixels enter in raster order on the slave stream, one word per clock while
// s_axis_tready is high, and each result word carries the horizontal and
// vertical Sobel gradients of one pixel with its column and row. Results lag
// one row and one column; a last-column pixel also yields the result of its
// own column in the row above, and last-row pixels yield the results of
// their own row, so one pixel gives zero, one, two or four result words. The
// datapath takes one pixel per clock while the master port accepts every
// word and each pixel yields at most one result: a pixel is read against the
// two line stores into the read stage, and its window update and gradients
// are registered into the result buffer when it commits. The result buffer
// drives the single master port, so a pixel that yields several results
// holds the input until its last result is taken; such a pixel lies in the
// last column or last row. Writing frame_width or frame_height restarts the
// frame at column 0, row 0; write them only while the unit is idle. The line
// stores need no clearing after reset.
module sobel_gradient_3x3_unit
    import sgr_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // APB register port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [APB_ADDR_W-1:0]                 paddr,
    input  logic [APB_DATA_W-1:0]                 pwdata,
    output logic [APB_DATA_W-1:0]                 prdata,
    output logic                                  pready,
    // Pixel stream in
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((PIXEL_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // [PIXEL_BITS-1:0] pixel
    // Gradient stream out
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [OUT_TDATA_W-1:0]                m_axis_tdata,  // grad_x, grad_y, out_col, out_row
    output logic                                  m_axis_tuser,  // frame_done
    output logic                                  m_axis_tlast   // last_of_run
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CMPW = ((CW > CFG_WIDTH_BITS) ? CW : CFG_WIDTH_BITS) + 1;
    localparam int PB   = PIXEL_BITS;

    // Configuration
    logic [CFG_WIDTH_BITS-1:0]  r_frame_width;
    logic [CFG_HEIGHT_BITS-1:0] r_frame_height;
    logic                       cfg_wr;
    t_reg_idx                   cfg_idx;
    logic [CMPW-1:0]            fw_ext;
    logic [CW-1:0]              wm1;
    logic [ROW_W-1:0]           hm1;

    // Input side position counters
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic             in_lastc;
    logic             in_lastr;
    logic             accept;

    // Read stage
    logic             r_a_valid;
    logic [PB-1:0]    r_a_pix;
    logic [CW-1:0]    r_a_col;
    logic [ROW_W-1:0] r_a_row;
    logic             r_a_lastc;
    logic             r_a_lastr;
    logic             r_a_fwd;
    logic [PB-1:0]    r_fwd_prev;
    logic [PB-1:0]    r_fwd_prev2;
    logic             commit;

    // Line store data
    logic [PB-1:0] rd_prev;
    logic [PB-1:0] rd_prev2;
    logic [PB-1:0] a_eff;
    logic [PB-1:0] b_eff;

    // Window, [column oldest..newest][row top, mid, bottom]
    logic [PB-1:0] r_win [3][3];
    logic [PB-1:0] n_win [3][3];
    logic [PB-1:0] lft0  [3];
    logic [PB-1:0] lft1  [3];
    logic          c_ge1;
    logic          c_ge2;
    logic          r_ge1;

    logic [PB-1:0]        k_left   [NUM_SLOTS][3];
    logic [PB-1:0]        k_center [NUM_SLOTS][3];
    logic [PB-1:0]        k_right  [NUM_SLOTS][3];
    logic signed [PB+2:0] k_gx     [NUM_SLOTS];
    logic signed [PB+2:0] k_gy     [NUM_SLOTS];

    t_result_set res_set;
    logic        q_can_load;
    logic [CW-1:0] col_m1;

    // ---------------------------------------------------------------
    // Register port
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[2]);

    always_comb begin
        unique case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    // Effective frame size: zero counts as one, width saturates at MAX_WIDTH.
    assign fw_ext = CMPW'(r_frame_width);

    always_comb begin
        priority if (fw_ext == '0) begin
            wm1 = '0;
        end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
            wm1 = CW'(MAX_WIDTH - 1);
        end else begin
            wm1 = CW'(fw_ext - CMPW'(1));
        end
    end

    assign hm1 = (r_frame_height == '0) ? '0 : r_frame_height - ROW_W'(1);

    // ---------------------------------------------------------------
    // Handshake and counters
    // ---------------------------------------------------------------
    assign commit        = r_a_valid && q_can_load;
    assign s_axis_tready = i_rst_n && (!r_a_valid || commit);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_lastc      = (r_col == wm1);
    assign in_lastr      = (r_row == hm1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_WIDTH_BITS'(640);
            r_frame_height <= CFG_HEIGHT_BITS'(480);
            r_col          <= '0;
            r_row          <= '0;
            r_a_valid      <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_FRAME_WIDTH:  r_frame_width  <= pwdata[CFG_WIDTH_BITS-1:0];
                    REG_FRAME_HEIGHT: r_frame_height <= pwdata[CFG_HEIGHT_BITS-1:0];
                    default: ;
                endcase
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                if (in_lastc) begin
                    r_col <= '0;
                    r_row <= in_lastr ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (accept) begin
                r_a_valid <= 1'b1;
            end else if (commit) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    // Read stage payload. With a one-pixel-wide frame the next pixel reads
    // the line store entry that the committing pixel writes in the same
    // cycle, so the written values are forwarded.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_pix     <= s_axis_tdata[PB-1:0];
            r_a_col     <= r_col;
            r_a_row     <= r_row;
            r_a_lastc   <= in_lastc;
            r_a_lastr   <= in_lastr;
            r_a_fwd     <= commit && (r_a_col == r_col);
            r_fwd_prev  <= r_a_pix;
            r_fwd_prev2 <= b_eff;
        end
    end

    // ---------------------------------------------------------------
    // Line stores
    // ---------------------------------------------------------------
    sgr_ram #(
        .WIDTH (PB),
        .DEPTH (MAX_WIDTH)
    ) u_line_prev (
        .i_clk   (i_clk),
        .i_we    (commit),
        .i_waddr (r_a_col),
        .i_wdata (r_a_pix),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (rd_prev)
    );

    sgr_ram #(
        .WIDTH (PB),
        .DEPTH (MAX_WIDTH)
    ) u_line_prev2 (
        .i_clk   (i_clk),
        .i_we    (commit),
        .i_waddr (r_a_col),
        .i_wdata (b_eff),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (rd_prev2)
    );

    assign b_eff = r_a_fwd ? r_fwd_prev  : rd_prev;
    assign a_eff = r_a_fwd ? r_fwd_prev2 : rd_prev2;

    // ---------------------------------------------------------------
    // Window update and kernel inputs
    // ---------------------------------------------------------------
    assign c_ge1 = (r_a_col != '0);
    assign c_ge2 = ({1'b0, r_a_col} >= (CW + 1)'(2));
    assign r_ge1 = (r_a_row != '0);

    always_comb begin
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        // The rows above are clamped to the top row near the frame's top.
        priority if (r_a_row == '0) begin
            n_win[2][0] = r_a_pix;
            n_win[2][1] = r_a_pix;
        end else if (r_a_row == ROW_W'(1)) begin
            n_win[2][0] = b_eff;
            n_win[2][1] = b_eff;
        end else begin
            n_win[2][0] = a_eff;
            n_win[2][1] = b_eff;
        end
        n_win[2][2] = r_a_pix;
    end

    // Left columns clamp at the frame's left edge; the right column of the
    // last-column results is the pixel's own column.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            lft0[j] = c_ge2 ? n_win[0][j] : n_win[1][j];
            lft1[j] = c_ge1 ? n_win[1][j] : n_win[2][j];
        end
        for (int j = 0; j < 3; j++) begin
            k_left[0][j]   = lft0[j];
            k_center[0][j] = n_win[1][j];
            k_right[0][j]  = n_win[2][j];
            k_left[1][j]   = lft1[j];
            k_center[1][j] = n_win[2][j];
            k_right[1][j]  = n_win[2][j];
            // On the last row the bottom neighbour is clamped to the pixel's
            // own row, so the window rows become mid, bottom, bottom.
            k_left[2][j]   = lft0[(j == 0) ? 1 : 2];
            k_center[2][j] = n_win[1][(j == 0) ? 1 : 2];
            k_right[2][j]  = n_win[2][(j == 0) ? 1 : 2];
            k_left[3][j]   = lft1[(j == 0) ? 1 : 2];
            k_center[3][j] = n_win[2][(j == 0) ? 1 : 2];
            k_right[3][j]  = n_win[2][(j == 0) ? 1 : 2];
        end
    end

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_kernel
        sgr_kernel #(
            .PIXEL_BITS (PB)
        ) u_kernel (
            .i_left   (k_left[g]),
            .i_center (k_center[g]),
            .i_right  (k_right[g]),
            .o_gx     (k_gx[g]),
            .o_gy     (k_gy[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (commit) begin
            r_win <= n_win;
        end
    end

    // ---------------------------------------------------------------
    // Result set
    // ---------------------------------------------------------------
    assign col_m1 = r_a_col - CW'(1);

    always_comb begin
        res_set.pend  = {r_a_lastc && r_a_lastr, r_a_lastr && c_ge1,
                         r_a_lastc && r_ge1, c_ge1 && r_ge1};
        for (int i = 0; i < NUM_SLOTS; i++) begin
            res_set.gx[i] = k_gx[i][GRAD_W-1:0];
            res_set.gy[i] = k_gy[i][GRAD_W-1:0];
        end
        res_set.col_a = COL_W'(col_m1);
        res_set.col_b = COL_W'(r_a_col);
        res_set.row_a = r_a_row - ROW_W'(1);
        res_set.row_b = r_a_row;
    end

    sgr_result_q u_result_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (commit),
        .i_set      (res_set),
        .o_can_load (q_can_load),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_tdata    (m_axis_tdata),
        .o_tuser    (m_axis_tuser),
        .o_tlast    (m_axis_tlast)
    );

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    // Forwarding from a committing pixel only happens in one-pixel-wide frames.
    a_fwd_only_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a_fwd) |-> (wm1 == '0))
        else $error("line store forwarding outside a one-pixel-wide frame");

    // The frame's final result is always the last word of its pixel.
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("frame_done on a word that is not the last of its pixel");

    // The frame's final pixel wraps both counters to zero.
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && in_lastc && in_lastr) |=> ((r_col == '0) && (r_row == '0)))
        else $error("position counters did not wrap at the end of the frame");

endmodule

[rtl/core/sgr_ram.sv]
// Generic simple dual-port RAM with registered, read-first output.
module sgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[rtl/core/sgr_kernel.sv]
// Horizontal and vertical 3x3 Sobel sums over one window.
module sgr_kernel #(
    parameter int PIXEL_BITS = 8
) (
    input  logic [PIXEL_BITS-1:0]        i_left   [3],
    input  logic [PIXEL_BITS-1:0]        i_center [3],
    input  logic [PIXEL_BITS-1:0]        i_right  [3],
    output logic signed [PIXEL_BITS+2:0] o_gx,
    output logic signed [PIXEL_BITS+2:0] o_gy
);

    localparam int SW = PIXEL_BITS + 3;

    logic [SW-1:0] sum_l;
    logic [SW-1:0] sum_r;
    logic [SW-1:0] sum_t;
    logic [SW-1:0] sum_b;

    // Each weighted sum is at most four times the largest pixel, so the
    // difference always fits in SW signed bits.
    assign sum_l = SW'(i_left[0]) + (SW'(i_left[1]) << 1) + SW'(i_left[2]);
    assign sum_r = SW'(i_right[0]) + (SW'(i_right[1]) << 1) + SW'(i_right[2]);
    assign sum_t = SW'(i_left[0]) + (SW'(i_center[0]) << 1) + SW'(i_right[0]);
    assign sum_b = SW'(i_left[2]) + (SW'(i_center[2]) << 1) + SW'(i_right[2]);

    assign o_gx = signed'(sum_r - sum_l);
    assign o_gy = signed'(sum_b - sum_t);

endmodule

[rtl/core/sgr_result_q.sv]
// Result buffer that hands out the results of one pixel, one word per cycle while the receiver is ready.
module sgr_result_q
    import sgr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  t_result_set            i_set,
    output logic                   o_can_load,
    output logic                   o_tvalid,
    input  logic                   i_tready,
    output logic [OUT_TDATA_W-1:0] o_tdata,
    output logic                   o_tuser,
    output logic                   o_tlast
);

    logic [NUM_SLOTS-1:0] r_pend;
    logic [NUM_SLOTS-1:0] n_pend;
    t_result_set          r_set;
    t_slot                sel;
    logic                 single;
    logic                 take;
    logic [COL_W-1:0]     col;
    logic [ROW_W-1:0]     row;

    // Lowest pending slot goes first.
    always_comb begin
        priority if (r_pend[0]) begin
            sel = t_slot'(0);
        end else if (r_pend[1]) begin
            sel = t_slot'(1);
        end else if (r_pend[2]) begin
            sel = t_slot'(2);
        end else begin
            sel = t_slot'(3);
        end
    end

    assign n_pend     = r_pend & (r_pend - NUM_SLOTS'(1));
    assign single     = (n_pend == '0);
    assign take       = (r_pend != '0) && i_tready;
    assign o_can_load = (r_pend == '0) || (take && single);

    assign col = sel[0] ? r_set.col_b : r_set.col_a;
    assign row = sel[1] ? r_set.row_b : r_set.row_a;

    assign o_tvalid = (r_pend != '0);
    assign o_tlast  = single;
    assign o_tuser  = (sel == t_slot'(NUM_SLOTS - 1));
    assign o_tdata  = OUT_TDATA_W'({row, col, r_set.gy[sel], r_set.gx[sel]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (i_load) begin
            r_pend <= i_set.pend;
        end else if (take) begin
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_set <= i_set;
        end
    end

endmodule
